// ===== rtl/madt_pkg.sv =====
// shared constants, types and helpers for the madt table parser
`timescale 1ns / 1ps
package madt_pkg;

   localparam int MAX_IOAPICS   = 8;
   localparam int MAX_OVERRIDES = 16;
   localparam int IOA_CNT_W     = $clog2(MAX_IOAPICS + 1);
   localparam int OVR_CNT_W     = $clog2(MAX_OVERRIDES + 1);
   localparam int OVR_AW        = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;
   // override store entry: irq source and gsi
   localparam int OVR_W         = 40;

   localparam logic [31:0] HDR_END = 32'd44;

   localparam logic [7:0] ET_IOAPIC   = 8'd1;
   localparam logic [7:0] ET_OVERRIDE = 8'd2;
   localparam logic [7:0] ET_LAPIC    = 8'd5;

   localparam logic [1:0] KIND_IOAPIC   = 2'd0;
   localparam logic [1:0] KIND_OVERRIDE = 2'd1;
   localparam logic [1:0] KIND_SUMMARY  = 2'd2;
   localparam logic [1:0] KIND_LOOKUP   = 2'd3;

   localparam logic [1:0] ST_OK_IOAPIC = 2'd0;
   localparam logic [1:0] ST_OK_NONE   = 2'd1;
   localparam logic [1:0] ST_BAD_SIG   = 2'd2;
   localparam logic [1:0] ST_BAD_SUM   = 2'd3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic do_byte;
      logic scan_rd;
      logic scan_step;
      logic emit_rec;
      logic emit_sum;
      logic emit_look;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic req_valid;
      logic is_lookup;
      logic has_rec;
      logic has_sum;
      logic scan_done;
      logic match;
      logic out_free;
   } dp_status_type;

   // "APIC" signature bytes
   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h41;
         2'd1:    val = 8'h50;
         2'd2:    val = 8'h49;
         default: val = 8'h43;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/madt_if.sv =====
// valid/ready channel interfaces for requests and responses
`timescale 1ns / 1ps
interface madt_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, func, data_byte, last_byte, input ready);
   modport sink (input valid, func, data_byte, last_byte, output ready);
endinterface

interface madt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  entry_id;
   logic [7:0]  src_bus;
   logic [31:0] address_value;
   logic [31:0] gsi_value;
   logic [15:0] irq_flags;
   logic [63:0] local_apic_address;
   logic        legacy_pic;
   logic [1:0]  status;
   logic [3:0]  ioapic_total;
   logic [4:0]  override_total;
   logic        last_of_run;
   modport source (output valid, kind, entry_id, src_bus, address_value, gsi_value,
                   irq_flags, local_apic_address, legacy_pic, status, ioapic_total,
                   override_total, last_of_run, input ready);
   modport sink (input valid, kind, entry_id, src_bus, address_value, gsi_value,
                 irq_flags, local_apic_address, legacy_pic, status, ioapic_total,
                 override_total, last_of_run, output ready);
endinterface

// ===== rtl/madt_ram.sv =====
// generic single-write single-read ram with registered read
`timescale 1ns / 1ps
module madt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ===== rtl/madt_ctrl.sv =====
// controller state machine: request intake, byte step, result emission, lookup scan
`timescale 1ns / 1ps
module madt_ctrl
   import madt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type stat,
   output logic          req_ready,
   output ctrl_cmd_type  cmd
);
   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_BYTE     = 7'b0000010,
      S_EMIT_REC = 7'b0000100,
      S_EMIT_SUM = 7'b0001000,
      S_SCAN_RD  = 7'b0010000,
      S_SCAN_CMP = 7'b0100000,
      S_ANSWER   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (stat.req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = stat.is_lookup ? S_SCAN_RD : S_BYTE;
            end
         end
         S_BYTE: begin
            cmd.do_byte = 1'b1;
            state_in    = S_EMIT_REC;
         end
         S_EMIT_REC: begin
            if (!stat.has_rec) begin
               state_in = S_EMIT_SUM;
            end else if (stat.out_free) begin
               cmd.emit_rec = 1'b1;
               state_in     = S_EMIT_SUM;
            end
         end
         S_EMIT_SUM: begin
            if (!stat.has_sum) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.emit_sum = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            if (stat.scan_done) begin
               state_in = S_ANSWER;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            cmd.scan_step = 1'b1;
            state_in      = stat.match ? S_ANSWER : S_SCAN_RD;
         end
         S_ANSWER: begin
            if (stat.out_free) begin
               cmd.emit_look = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

// ===== rtl/madt_datapath.sv =====
// datapath: table walk state, override store, lookup compare and response register
`timescale 1ns / 1ps
module madt_datapath
   import madt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   input  logic          ctrl_ready,
   output dp_status_type stat,
   madt_req_if.sink      req,
   madt_rsp_if.source    rsp
);
   // request registers
   logic [7:0] b_ff;
   logic       last_ff;

   // table state
   logic [31:0]          pos_ff, pos_in;
   logic [31:0]          dlen_ff, dlen_in;
   logic [7:0]           sum_ff, sum_in;
   logic                 sigok_ff, sigok_in;
   logic [31:0]          estart_ff, estart_in;
   logic [7:0]           etype_ff, etype_in;
   logic [7:0]           esize_ff, esize_in;
   logic                 stopped_ff, stopped_in;
   logic [63:0]          fshift_ff, fshift_in;
   logic [7:0]           ioa_id_ff, ioa_id_in;
   logic [IOA_CNT_W-1:0] ioa_cnt_ff, ioa_cnt_in;
   logic [OVR_CNT_W-1:0] ovr_cnt_ff, ovr_cnt_in;
   logic [63:0]          lapic_ff, lapic_in;
   logic                 legacy_ff, legacy_in;
   logic                 in_table_ff, in_table_in;

   // latched step results
   logic        has_rec_ff, has_rec_in;
   logic        has_sum_ff, has_sum_in;
   logic [1:0]  rec_kind_ff, rec_kind_in;
   logic [7:0]  rec_id_ff, rec_id_in;
   logic [7:0]  rec_bus_ff, rec_bus_in;
   logic [31:0] rec_addr_ff, rec_addr_in;
   logic [31:0] rec_gsi_ff, rec_gsi_in;
   logic [15:0] rec_flags_ff, rec_flags_in;
   logic [1:0]  st_ff, st_in;

   // lookup scan
   logic [OVR_CNT_W-1:0] scan_idx_ff;
   logic [31:0]          ans_ff;
   logic [OVR_W-1:0]     rd_data;

   // override store write
   logic              ovr_wr;
   logic [OVR_AW-1:0] ovr_wr_addr;
   logic [OVR_W-1:0]  ovr_wr_data;

   // response register
   logic        rv_ff;
   logic [1:0]  o_kind_ff;
   logic [7:0]  o_id_ff;
   logic [7:0]  o_bus_ff;
   logic [31:0] o_addr_ff;
   logic [31:0] o_gsi_ff;
   logic [15:0] o_flags_ff;
   logic [63:0] o_lapic_ff;
   logic        o_legacy_ff;
   logic [1:0]  o_st_ff;
   logic [3:0]  o_ioa_ff;
   logic [4:0]  o_ovr_ff;
   logic        o_last_ff;

   // walk scratch values
   logic [31:0] p;
   logic [31:0] off;
   logic [63:0] fs_new;
   logic        ioa_rec;
   logic        ovr_rec;

   logic out_free;
   assign out_free = !rv_ff || rsp.ready;

   // status to the controller
   assign stat.req_valid = req.valid;
   assign stat.is_lookup = req.func;
   assign stat.has_rec   = has_rec_ff;
   assign stat.has_sum   = has_sum_ff;
   assign stat.scan_done = (scan_idx_ff >= ovr_cnt_ff);
   assign stat.match     = (rd_data[39:32] == b_ff);
   assign stat.out_free  = out_free;

   madt_ram #(
      .WIDTH (OVR_W),
      .DEPTH (MAX_OVERRIDES)
   ) u_ovr_ram (
      .clock   (clock),
      .wr_en   (ovr_wr),
      .wr_addr (ovr_wr_addr),
      .wr_data (ovr_wr_data),
      .rd_en   (cmd.scan_rd),
      .rd_addr (scan_idx_ff[OVR_AW-1:0]),
      .rd_data (rd_data)
   );

   // one table byte: header fields, checksum and entry walk
   always_comb begin
      pos_in      = pos_ff;
      dlen_in     = dlen_ff;
      sum_in      = sum_ff;
      sigok_in    = sigok_ff;
      estart_in   = estart_ff;
      etype_in    = etype_ff;
      esize_in    = esize_ff;
      stopped_in  = stopped_ff;
      fshift_in   = fshift_ff;
      ioa_id_in   = ioa_id_ff;
      ioa_cnt_in  = ioa_cnt_ff;
      ovr_cnt_in  = ovr_cnt_ff;
      lapic_in    = lapic_ff;
      legacy_in   = legacy_ff;
      in_table_in = in_table_ff;
      has_rec_in  = has_rec_ff;
      has_sum_in  = has_sum_ff;
      rec_kind_in = rec_kind_ff;
      rec_id_in   = rec_id_ff;
      rec_bus_in  = rec_bus_ff;
      rec_addr_in = rec_addr_ff;
      rec_gsi_in  = rec_gsi_ff;
      rec_flags_in = rec_flags_ff;
      st_in       = st_ff;
      ovr_wr      = 1'b0;
      ovr_wr_addr = ovr_cnt_ff[OVR_AW-1:0];
      ovr_wr_data = '0;
      p           = '0;
      off         = '0;
      fs_new      = '0;
      ioa_rec     = 1'b0;
      ovr_rec     = 1'b0;
      if (cmd.do_byte) begin
         // new table starts from cleared walk state
         if (!in_table_ff) begin
            pos_in     = '0;
            dlen_in    = '0;
            sum_in     = '0;
            sigok_in   = 1'b1;
            estart_in  = HDR_END;
            etype_in   = '0;
            esize_in   = '0;
            stopped_in = 1'b0;
            fshift_in  = '0;
            ioa_cnt_in = '0;
            ovr_cnt_in = '0;
            lapic_in   = '0;
         end
         has_rec_in  = 1'b0;
         in_table_in = 1'b1;
         p           = pos_in;
         ovr_wr_addr = ovr_cnt_in[OVR_AW-1:0];
         if (p != 32'hFFFF_FFFF) begin
            pos_in = p + 32'd1;
         end
         if (p < 32'd8 || p < dlen_in) begin
            sum_in = sum_in + b_ff;
         end
         if (p < 32'd4) begin
            if (b_ff != sig_byte(p[1:0])) begin
               sigok_in = 1'b0;
            end
         end else if (p < 32'd8) begin
            dlen_in = dlen_in | ({24'd0, b_ff} << {p[1:0], 3'b000});
         end else if (sigok_in && p < dlen_in) begin
            if (p >= 32'd36 && p < 32'd40) begin
               lapic_in = lapic_in | ({56'd0, b_ff} << {p[1:0], 3'b000});
            end else if (p == 32'd40) begin
               legacy_in = b_ff[0];
            end else if (p >= HDR_END && !stopped_in && p >= estart_in) begin
               off = p - estart_in;
               if (off == 32'd0) begin
                  // entry type byte
                  etype_in  = b_ff;
                  fshift_in = '0;
                  if ({1'b0, estart_in} + 33'd2 > {1'b0, dlen_in}) begin
                     stopped_in = 1'b1;
                  end
               end else if (off == 32'd1) begin
                  // entry length byte
                  esize_in = b_ff;
                  if (b_ff < 8'd2 ||
                      {1'b0, estart_in} + {25'd0, b_ff} > {1'b0, dlen_in}) begin
                     stopped_in = 1'b1;
                  end else if (b_ff == 8'd2) begin
                     estart_in = estart_in + 32'd2;
                  end
               end else begin
                  // entry body
                  fs_new    = {b_ff, fshift_in[63:8]};
                  fshift_in = fs_new;
                  if (etype_in == ET_IOAPIC && esize_in >= 8'd12 &&
                      32'(ioa_cnt_in) < 32'(MAX_IOAPICS)) begin
                     if (off == 32'd2) begin
                        ioa_id_in = b_ff;
                     end
                     if (off == 32'd11) begin
                        ioa_rec = 1'b1;
                     end
                  end else if (etype_in == ET_OVERRIDE && esize_in >= 8'd10 &&
                               off == 32'd9 &&
                               32'(ovr_cnt_in) < 32'(MAX_OVERRIDES)) begin
                     ovr_rec = 1'b1;
                  end else if (etype_in == ET_LAPIC && esize_in >= 8'd12 &&
                               off == 32'd11) begin
                     lapic_in = fs_new;
                  end
                  if (off == {24'd0, esize_in} - 32'd1) begin
                     estart_in = estart_in + {24'd0, esize_in};
                  end
               end
            end
         end
         // record capture
         if (ioa_rec) begin
            has_rec_in   = 1'b1;
            rec_kind_in  = KIND_IOAPIC;
            rec_id_in    = ioa_id_in;
            rec_bus_in   = '0;
            rec_addr_in  = fs_new[31:0];
            rec_gsi_in   = fs_new[63:32];
            rec_flags_in = '0;
            ioa_cnt_in   = ioa_cnt_in + IOA_CNT_W'(1);
         end
         if (ovr_rec) begin
            has_rec_in   = 1'b1;
            rec_kind_in  = KIND_OVERRIDE;
            rec_id_in    = fs_new[15:8];
            rec_bus_in   = fs_new[7:0];
            rec_addr_in  = '0;
            rec_gsi_in   = fs_new[47:16];
            rec_flags_in = fs_new[63:48];
            ovr_wr       = 1'b1;
            ovr_wr_data  = {fs_new[15:8], fs_new[47:16]};
            ovr_cnt_in   = ovr_cnt_in + OVR_CNT_W'(1);
         end
         // summary on the final byte
         has_sum_in = last_ff;
         if (last_ff) begin
            in_table_in = 1'b0;
            if (!sigok_in || pos_in < 32'd4) begin
               st_in = ST_BAD_SIG;
            end else if (dlen_in < HDR_END || pos_in < dlen_in || sum_in != 8'd0) begin
               st_in = ST_BAD_SUM;
            end else if (ioa_cnt_in != '0) begin
               st_in = ST_OK_IOAPIC;
            end else begin
               st_in = ST_OK_NONE;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         dlen_ff     <= '0;
         sum_ff      <= '0;
         sigok_ff    <= 1'b1;
         estart_ff   <= HDR_END;
         etype_ff    <= '0;
         esize_ff    <= '0;
         stopped_ff  <= 1'b0;
         fshift_ff   <= '0;
         ioa_cnt_ff  <= '0;
         ovr_cnt_ff  <= '0;
         lapic_ff    <= '0;
         legacy_ff   <= 1'b1;
         in_table_ff <= 1'b0;
         has_rec_ff  <= 1'b0;
         has_sum_ff  <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         dlen_ff     <= dlen_in;
         sum_ff      <= sum_in;
         sigok_ff    <= sigok_in;
         estart_ff   <= estart_in;
         etype_ff    <= etype_in;
         esize_ff    <= esize_in;
         stopped_ff  <= stopped_in;
         fshift_ff   <= fshift_in;
         ioa_cnt_ff  <= ioa_cnt_in;
         ovr_cnt_ff  <= ovr_cnt_in;
         lapic_ff    <= lapic_in;
         legacy_ff   <= legacy_in;
         in_table_ff <= in_table_in;
         has_rec_ff  <= has_rec_in;
         has_sum_ff  <= has_sum_in;
      end
   end

   // payload registers: request, record and lookup scan
   always_ff @(posedge clock) begin
      ioa_id_ff    <= ioa_id_in;
      rec_kind_ff  <= rec_kind_in;
      rec_id_ff    <= rec_id_in;
      rec_bus_ff   <= rec_bus_in;
      rec_addr_ff  <= rec_addr_in;
      rec_gsi_ff   <= rec_gsi_in;
      rec_flags_ff <= rec_flags_in;
      st_ff        <= st_in;
      if (cmd.load_req) begin
         b_ff        <= req.data_byte;
         last_ff     <= req.last_byte;
         scan_idx_ff <= '0;
         ans_ff      <= {24'd0, req.data_byte};
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + OVR_CNT_W'(1);
         if (rd_data[39:32] == b_ff) begin
            ans_ff <= rd_data[31:0];
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.emit_rec || cmd.emit_sum || cmd.emit_look) begin
         rv_ff <= 1'b1;
      end else if (rsp.ready) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_rec || cmd.emit_sum || cmd.emit_look) begin
         o_lapic_ff  <= lapic_ff;
         o_legacy_ff <= legacy_ff;
         o_ioa_ff    <= 4'(ioa_cnt_ff);
         o_ovr_ff    <= 5'(ovr_cnt_ff);
         o_kind_ff   <= KIND_SUMMARY;
         o_id_ff     <= '0;
         o_bus_ff    <= '0;
         o_addr_ff   <= '0;
         o_gsi_ff    <= '0;
         o_flags_ff  <= '0;
         o_st_ff     <= ST_OK_IOAPIC;
         o_last_ff   <= 1'b1;
         if (cmd.emit_rec) begin
            o_kind_ff  <= rec_kind_ff;
            o_id_ff    <= rec_id_ff;
            o_bus_ff   <= rec_bus_ff;
            o_addr_ff  <= rec_addr_ff;
            o_gsi_ff   <= rec_gsi_ff;
            o_flags_ff <= rec_flags_ff;
            o_last_ff  <= !has_sum_ff;
         end else if (cmd.emit_sum) begin
            o_st_ff <= st_ff;
         end else begin
            o_kind_ff <= KIND_LOOKUP;
            o_id_ff   <= b_ff;
            o_gsi_ff  <= ans_ff;
         end
      end
   end

   assign req.ready = ctrl_ready;

   assign rsp.valid              = rv_ff;
   assign rsp.kind               = o_kind_ff;
   assign rsp.entry_id           = o_id_ff;
   assign rsp.src_bus            = o_bus_ff;
   assign rsp.address_value      = o_addr_ff;
   assign rsp.gsi_value          = o_gsi_ff;
   assign rsp.irq_flags          = o_flags_ff;
   assign rsp.local_apic_address = o_lapic_ff;
   assign rsp.legacy_pic         = o_legacy_ff;
   assign rsp.status             = o_st_ff;
   assign rsp.ioapic_total       = o_ioa_ff;
   assign rsp.override_total     = o_ovr_ff;
   assign rsp.last_of_run        = o_last_ff;
endmodule

// ===== rtl/madt_table_parser_top.sv =====
// top level of the madt table parser
`timescale 1ns / 1ps
// Usage:
//   req channel: one request per handshake. func 0 feeds one table byte
//   (data_byte, with last_byte high on the final byte); func 1 asks for the
//   gsi of a legacy irq given in data_byte.
//   rsp channel: results in order. a table byte gives no result, an ioapic or
//   override record when an entry completes, and a summary on the last byte;
//   last_of_run marks the final result of a request. a lookup gives one answer.
//   Timing: a table byte passes the byte step, record slot and summary slot
//   before ready returns; the record and summary slots stall only while the
//   receiver stalls. a lookup reads the stored overrides one at a time
//   through the single read port of the override store, each read followed
//   by a compare; a match ends the scan early.
//   The rsp side has its own output register; when the receiver stalls, the
//   pending result holds and the block waits before writing the next one.
//   Reset (synchronous, active high) clears the counts, the local apic
//   address and the walk state, sets the legacy pic flag, and drops rsp valid.
//   The override store is not cleared; only entries below the count are read.
module madt_table_parser_top
   import madt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   madt_req_if.sink   req,
   madt_rsp_if.source rsp
);
   ctrl_cmd_type  cmd;
   dp_status_type stat;
   logic          ctrl_ready;

   madt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .req_ready (ctrl_ready),
      .cmd       (cmd)
   );

   madt_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .ctrl_ready (ctrl_ready),
      .stat       (stat),
      .req        (req),
      .rsp        (rsp)
   );
endmodule

// ===== rtl/madt_checker.sv =====
// port-level assertions for the madt table parser, bound to the top level
`timescale 1ns / 1ps
module madt_checker
   import madt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_ioapic_total,
   input logic [4:0] rsp_override_total,
   input logic       rsp_last_of_run
);
   // a stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no response straight after reset
   assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // status only carried by a summary
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SUMMARY |-> rsp_status == ST_OK_IOAPIC)
      else $error("status outside a summary");

   // summaries and lookup answers end their run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SUMMARY || rsp_kind == KIND_LOOKUP)
      |-> rsp_last_of_run)
      else $error("summary or answer not last of run");

   // record totals within capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_ioapic_total) <= 32'(MAX_IOAPICS) &&
                    32'(rsp_override_total) <= 32'(MAX_OVERRIDES))
      else $error("record total over capacity");
endmodule

bind madt_table_parser_top madt_checker u_madt_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_kind           (rsp.kind),
   .rsp_status         (rsp.status),
   .rsp_ioapic_total   (rsp.ioapic_total),
   .rsp_override_total (rsp.override_total),
   .rsp_last_of_run    (rsp.last_of_run)
);
